/* rtl/rse_pkg.sv */
// Shared types and constants for the RPN stack evaluator.
// Depends on nothing; the divider and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package rse_pkg;

  localparam int STACK_DEPTH_DEF = 8;

  // operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // mode codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_OPER = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  // Q16.16 bounds
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               mode;
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [3:0]         stack_count;
    logic [2:0]         status;
  } out_t;

endpackage

/* rtl/rse_stack_mem.sv */
// Stack storage: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module rse_stack_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic signed [31:0]  wdata,
  input  logic [AW-1:0]       raddr,
  output logic signed [31:0]  rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rse_divider.sv */
// Radix-2 restoring divider for (dividend * 2^16) / divisor on Q16.16 values,
// one quotient bit per cycle, result truncated toward zero and saturated.
// Depends on rse_pkg for the Q16.16 bounds.
`timescale 1ns / 1ps

module rse_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient,
  output logic               sat
);

  localparam int QBITS = 33;
  localparam int CW    = $clog2(QBITS + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [32:0]   dvd_r, dvd_nxt;
  logic [32:0]   quo_r, quo_nxt;
  logic [31:0]   dsr_r, dsr_nxt;
  logic          neg_r, neg_nxt;
  logic          ovf_r, ovf_nxt;

  logic [31:0] mag_a, mag_b;
  logic        start_ovf;
  logic [32:0] trial;
  logic        ge;
  logic [33:0] q_signed;
  logic        pos_big, neg_big;

  always_comb begin
    mag_a     = dividend[31] ? 32'(-dividend) : 32'(dividend);
    mag_b     = divisor[31]  ? 32'(-divisor)  : 32'(divisor);
    // Quotient needs more than 33 bits when the bits above the 33 shifted in
    // already reach the divisor.
    start_ovf = {17'd0, mag_a[31:17]} >= mag_b;
    trial     = {rem_r[31:0], dvd_r[32]};
    ge        = trial >= {1'b0, dsr_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    ovf_nxt  = ovf_r;

    if (start) begin
      neg_nxt = dividend[31] ^ divisor[31];
      dsr_nxt = mag_b;
      ovf_nxt = start_ovf;
      rem_nxt = {18'd0, mag_a[31:17]};
      dvd_nxt = {mag_a[16:0], 16'd0};
      quo_nxt = '0;
      cnt_nxt = CW'(QBITS);
      if (start_ovf) begin
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? (trial - {1'b0, dsr_r}) : trial;
      quo_nxt = {quo_r[31:0], ge};
      dvd_nxt = {dvd_r[31:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
  end

  // Apply the sign and clamp.
  always_comb begin
    q_signed = neg_r ? 34'(-{1'b0, quo_r}) : {1'b0, quo_r};
    pos_big  = !neg_r && (quo_r > 33'h0_7FFF_FFFF);
    neg_big  = neg_r && (quo_r > 33'h0_8000_0000);
    sat      = ovf_r || pos_big || neg_big;
    if (sat) begin
      quotient = neg_r ? rse_pkg::Q_MIN : rse_pkg::Q_MAX;
    end else begin
      quotient = q_signed[31:0];
    end
  end

  assign done = done_r;

endmodule

/* rtl/rpn_stack_evaluator.sv */
// RPN stack evaluator top level: control sequencer, stack memory and divider.
// Depends on rse_pkg, rse_stack_mem and rse_divider.
`timescale 1ns / 1ps

// Reverse Polish calculator on signed Q16.16 values. Each input item either
// pushes its value (mode 0) or pops the top two entries and pushes
// second-from-top OP top (mode 1: add, subtract, multiply, divide). Every item
// returns one result item: the new top (zero on an empty stack), the depth in
// four bits, and a status: ok, underflow (item ignored), overflow (push ignored),
// divide by zero (result clamped by the dividend's sign) or saturated. The
// stack lives in a single-port-write, registered-read memory; the top entry is
// also held in a register, so only the second entry is read from memory. One
// item is in work at a time. A push, an ignored item or a stack error is staged
// in the result register when it is taken; add, subtract and divide by zero
// first pass the memory read state, multiply also a registered 32x32 product,
// and divide waits for the divider, which produces one of 33 quotient bits per
// cycle. The staged result moves into the output register once it is free.
// The next item is taken the cycle after the result moves into the output
// register; the previous result may still wait in the output register, and a
// result that is not taken holds the sequencer.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rse_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rse_pkg::out_t  out_data
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic signed [31:0] top_r, top_nxt;
  logic [1:0]         op_r, op_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  rse_pkg::out_t      res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  rse_pkg::out_t      out_data_r, out_data_nxt;

  // memory ports
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;

  // divider ports
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_q;
  logic               div_sat;

  // finishing an operation
  logic               fin;
  logic signed [31:0] fin_val;
  logic [2:0]         fin_stat;

  logic               in_acc;
  logic               out_free;
  logic [LVL_W-1:0]   level_m1;
  logic [32:0]        sum33;
  logic signed [47:0] prod_sh;

  rse_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rse_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mem_rdata),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_q),
    .sat      (div_sat)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign level_m1 = level_r - LVL_W'(1);

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    top_nxt   = top_r;
    op_nxt    = op_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;

    // Second entry sits at level - 2; read it every cycle, the read only matters on the
    // cycle an operation is taken; the result is written back to the same address.
    mem_raddr = AW'(level_r - LVL_W'(2));
    mem_we    = 1'b0;
    mem_waddr = mem_raddr;
    mem_wdata = top_r;
    div_start = 1'b0;

    fin      = 1'b0;
    fin_val  = top_r;
    fin_stat = rse_pkg::ST_OK;

    sum33   = '0;
    prod_sh = prod_r[63:16];   // arithmetic shift: floor toward minus infinity

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_data.operation;
          state_nxt = S_EMIT;
          if (in_data.mode == rse_pkg::MODE_PUSH) begin
            if (level_r >= LVL_W'(STACK_DEPTH)) begin
              // full: drop the push, report the unchanged top
              res_nxt.top_value   = top_r;
              res_nxt.stack_count = 4'(level_r);
              res_nxt.status      = rse_pkg::ST_OVER;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(level_r);
              mem_wdata = in_data.value;
              level_nxt = level_r + LVL_W'(1);
              top_nxt   = in_data.value;
              res_nxt.top_value   = in_data.value;
              res_nxt.stack_count = 4'(level_r + LVL_W'(1));
              res_nxt.status      = rse_pkg::ST_OK;
            end
          end else if (level_r < LVL_W'(2)) begin
            // too few entries: drop the item
            res_nxt.top_value   = (level_r == '0) ? 32'sd0 : top_r;
            res_nxt.stack_count = 4'(level_r);
            res_nxt.status      = rse_pkg::ST_UNDER;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        // mem_rdata holds the second entry, top_r the top
        case (op_r)
          rse_pkg::OP_ADD, rse_pkg::OP_SUB: begin
            if (op_r == rse_pkg::OP_ADD) begin
              sum33 = {mem_rdata[31], mem_rdata} + {top_r[31], top_r};
            end else begin
              sum33 = {mem_rdata[31], mem_rdata} - {top_r[31], top_r};
            end
            fin = 1'b1;
            if (sum33[32] != sum33[31]) begin
              fin_val  = sum33[32] ? rse_pkg::Q_MIN : rse_pkg::Q_MAX;
              fin_stat = rse_pkg::ST_SAT;
            end else begin
              fin_val = sum33[31:0];
            end
          end
          rse_pkg::OP_MUL: begin
            prod_nxt  = 64'(mem_rdata) * 64'(top_r);
            state_nxt = S_MUL;
          end
          default: begin
            if (top_r == 32'sd0) begin
              fin      = 1'b1;
              fin_val  = mem_rdata[31] ? rse_pkg::Q_MIN : rse_pkg::Q_MAX;
              fin_stat = rse_pkg::ST_DIVZ;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        endcase
      end

      S_MUL: begin
        fin = 1'b1;
        // in range only if bits 47..31 of the shifted product agree
        if ((prod_sh[47:31] != 17'h0_0000) && (prod_sh[47:31] != 17'h1_FFFF)) begin
          fin_val  = prod_sh[47] ? rse_pkg::Q_MIN : rse_pkg::Q_MAX;
          fin_stat = rse_pkg::ST_SAT;
        end else begin
          fin_val = prod_sh[31:0];
        end
      end

      S_DIV: begin
        if (div_done) begin
          fin      = 1'b1;
          fin_val  = div_q;
          fin_stat = div_sat ? rse_pkg::ST_SAT : rse_pkg::ST_OK;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Write the result over the second entry, pop one, stage the result item.
    if (fin) begin
      mem_we    = 1'b1;
      mem_wdata = fin_val;
      level_nxt = level_m1;
      top_nxt   = fin_val;
      res_nxt.top_value   = fin_val;
      res_nxt.stack_count = 4'(level_m1);
      res_nxt.status      = fin_stat;
      state_nxt = S_EMIT;
    end
  end

  // Output register: load from the staged result, hold until taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (state_r == S_EMIT && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    op_r       <= op_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Depth never runs past the stack size.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  // One item in work: intake closes right after an item is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second item taken while one is in work");

  // A divider result only arrives while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide wait");

  // A push that writes memory grows the stack by exactly one.
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_IDLE) |=> level_r == $past(level_r) + LVL_W'(1))
    else $error("push did not grow the stack by one");

  // An operation that writes back shrinks the stack by exactly one.
  a_op_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> level_r == $past(level_r) - LVL_W'(1))
    else $error("operation did not shrink the stack by one");

endmodule
